// ----- design/edp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Exact double dot product package
// Shared constants for the exact binary64 dot product accumulator.
// ----------------------------------------------------------------------------
package edp_pkg;

  localparam int unsigned ACC_WORDS_DEF = 68;
  localparam int unsigned NORM_TOP      = 1126;
  localparam int unsigned EXP_OFFSET    = 1125;

  localparam logic [63:0] QNAN_BITS = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] INF_BITS  = 64'h7FF0_0000_0000_0000;
  localparam logic [10:0] EXP_MAX   = 11'h7FF;

endpackage

// ----- design/edp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Exact double dot product channels
// Operand pair channel and result channel, each with valid and ready.
// ----------------------------------------------------------------------------
interface edp_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] a_bits;
  logic [63:0] b_bits;
  logic        last;

  modport source (output valid, a_bits, b_bits, last, input ready);
  modport sink   (input valid, a_bits, b_bits, last, output ready);
endinterface

interface edp_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_bits;

  modport source (output valid, result_bits, input ready);
  modport sink   (input valid, result_bits, output ready);
endinterface

// ----- design/edp_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module edp_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 68
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- design/exact_double_dot_product_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Exact double dot product
// Kulisch style exact accumulation of binary64 products, rounded once.
// ----------------------------------------------------------------------------
// Operand pairs arrive as beats on in_i; the beat with last set closes the
// vector and causes one beat on out_o with the sum rounded to nearest even.
// A finite nonzero product is accepted, formed in the shared 32 by 32
// multiplier, aligned, and added into each accumulator word it touches by a
// read and a write through the single RAM read and write port: the usual
// three words, plus each word a carry ripples into. Zero, NaN and infinite
// pairs are only accepted. The closing beat then has the flags checked, the
// RAM swept, the sum normalised and rounded, and the result loaded into the
// output register. Special results skip all but the first and last steps.
// A result waits in an output register while the receiver stalls; the next
// vector is accepted meanwhile, and its own result waits for the register.
// Reset clears the word valid bits and the flags, so the store reads as zero
// at once; loading a result into the output register clears them again.
// ----------------------------------------------------------------------------
module exact_double_dot_product_top
  import edp_pkg::*;
#(
  parameter int unsigned ACC_WORDS = ACC_WORDS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  edp_in_if.sink    in_i,
  edp_out_if.source out_o
);

  localparam int unsigned AW = $clog2(ACC_WORDS);
  localparam int unsigned CW = $clog2(ACC_WORDS + 1);
  localparam int unsigned PW = $clog2(ACC_WORDS * 64) + 2;
  localparam logic [AW-1:0] TOP_ADDR = AW'(ACC_WORDS - 1);
  localparam logic [CW-1:0] CNT_END  = CW'(ACC_WORDS);
  localparam logic [PW-1:0] P_NORM   = PW'(NORM_TOP);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL  = 4'd1;
  localparam logic [3:0] S_SHF  = 4'd2;
  localparam logic [3:0] S_ARD  = 4'd3;
  localparam logic [3:0] S_AWR  = 4'd4;
  localparam logic [3:0] S_FIN  = 4'd5;
  localparam logic [3:0] S_TOPR = 4'd6;
  localparam logic [3:0] S_TOPW = 4'd7;
  localparam logic [3:0] S_SWP  = 4'd8;
  localparam logic [3:0] S_SEL  = 4'd9;
  localparam logic [3:0] S_NORM = 4'd10;
  localparam logic [3:0] S_RND  = 4'd11;
  localparam logic [3:0] S_OUT  = 4'd12;

  logic [3:0]         state_q, state_d;
  logic               nan_q, nan_d, pinf_q, pinf_d, minf_q, minf_d;
  logic               last_q, last_d, neg_q, neg_d;
  logic [52:0]        ma_q, ma_d, mb_q, mb_d;
  logic [5:0]         sh_q, sh_d;
  logic [AW-1:0]      widx_q, widx_d;
  logic [1:0]         chunk_q, chunk_d;
  logic [2:0]         mcnt_q, mcnt_d;
  logic [1:0]         ppk_q, ppk_d;
  logic [63:0]        pp_q, pp_d;
  logic [105:0]       prod_q, prod_d;
  logic [191:0]       v_q, v_d;
  logic               carry_q, carry_d;
  logic [ACC_WORDS-1:0] valid_q, valid_d;
  logic               rvalid_q;
  logic               sign_q, sign_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [63:0]        prev_q, prev_d, hi_q, hi_d, lo_q, lo_d;
  logic               orb_q, orb_d, found_q, found_d, stlo_q, stlo_d;
  logic [AW-1:0]      top_q, top_d;
  logic [127:0]       win_q, win_d;
  logic [PW-1:0]      p_q, p_d;
  logic               st_q, st_d;
  logic [63:0]        res_q, res_d;
  logic               out_valid_q, out_valid_d;
  logic [63:0]        out_data_q, out_data_d;

  logic               we;
  logic [AW-1:0]      waddr, raddr;
  logic [63:0]        wdata, rdata, rword;

  logic [10:0]        ea, eb, ea_eff, eb_eff;
  logic [51:0]        fa, fb;
  logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic [11:0]        pos;
  logic [31:0]        opa, opb;
  logic [63:0]        xw, mag;
  logic [64:0]        sum65;
  logic [53:0]        q54;
  logic [52:0]        qf;
  logic [PW-1:0]      pf, ex;
  logic               inc;

  edp_ram #(.WIDTH(64), .DEPTH(ACC_WORDS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rword = rvalid_q ? rdata : 64'd0;

  assign ea = in_i.a_bits[62:52];
  assign eb = in_i.b_bits[62:52];
  assign fa = in_i.a_bits[51:0];
  assign fb = in_i.b_bits[51:0];
  assign a_nan  = (ea == EXP_MAX) && (fa != 52'd0);
  assign b_nan  = (eb == EXP_MAX) && (fb != 52'd0);
  assign a_inf  = (ea == EXP_MAX) && (fa == 52'd0);
  assign b_inf  = (eb == EXP_MAX) && (fb == 52'd0);
  assign a_zero = (ea == 11'd0) && (fa == 52'd0);
  assign b_zero = (eb == 11'd0) && (fb == 52'd0);
  assign ea_eff = (ea == 11'd0) ? 11'd1 : ea;
  assign eb_eff = (eb == 11'd0) ? 11'd1 : eb;
  assign pos    = 12'({1'b0, ea_eff} + {1'b0, eb_eff} - 12'd2);

  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.result_bits = out_data_q;

  always_comb begin
    opa = mcnt_q[1] ? {11'd0, ma_q[52:32]} : ma_q[31:0];
    opb = mcnt_q[0] ? {11'd0, mb_q[52:32]} : mb_q[31:0];
    case (chunk_q)
      2'd0:    xw = v_q[63:0];
      2'd1:    xw = v_q[127:64];
      2'd2:    xw = v_q[191:128];
      default: xw = 64'd0;
    endcase
    if (neg_q) begin
      sum65 = {1'b0, rword} - {1'b0, xw} - {64'd0, carry_q};
    end else begin
      sum65 = {1'b0, rword} + {1'b0, xw} + {64'd0, carry_q};
    end
    mag = sign_q ? (~rword + {63'd0, carry_q}) : rword;
    inc = win_q[74] && (st_q || (|win_q[73:0]) || win_q[75]);
    q54 = {1'b0, win_q[127:75]} + {53'd0, inc};
    if (q54[53]) begin
      qf = q54[53:1];
      pf = p_q + PW'(1);
    end else begin
      qf = q54[52:0];
      pf = p_q;
    end
    ex = pf - PW'(EXP_OFFSET);
  end

  always_comb begin
    state_d = state_q;
    nan_d = nan_q; pinf_d = pinf_q; minf_d = minf_q;
    last_d = last_q; neg_d = neg_q; ma_d = ma_q; mb_d = mb_q; sh_d = sh_q;
    widx_d = widx_q; chunk_d = chunk_q; mcnt_d = mcnt_q; ppk_d = ppk_q;
    pp_d = pp_q; prod_d = prod_q; v_d = v_q; carry_d = carry_q;
    valid_d = valid_q; sign_d = sign_q; cnt_d = cnt_q; prev_d = prev_q;
    hi_d = hi_q; lo_d = lo_q; orb_d = orb_q; found_d = found_q;
    stlo_d = stlo_q; top_d = top_q; win_d = win_q; p_d = p_q; st_d = st_q;
    res_d = res_q;
    out_valid_d = out_valid_q; out_data_d = out_data_q;
    we = 1'b0; waddr = widx_q; wdata = sum65[63:0]; raddr = widx_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          last_d  = in_i.last;
          neg_d   = in_i.a_bits[63] ^ in_i.b_bits[63];
          ma_d    = {(ea != 11'd0), fa};
          mb_d    = {(eb != 11'd0), fb};
          sh_d    = pos[5:0];
          widx_d  = AW'(pos[11:6]);
          chunk_d = 2'd0;
          carry_d = 1'b0;
          mcnt_d  = 3'd0;
          prod_d  = 106'd0;
          state_d = in_i.last ? S_FIN : S_IDLE;
          if (a_nan || b_nan) begin
            nan_d = 1'b1;
          end else if (a_inf || b_inf) begin
            if (a_zero || b_zero) begin
              nan_d = 1'b1;
            end else if (in_i.a_bits[63] ^ in_i.b_bits[63]) begin
              minf_d = 1'b1;
            end else begin
              pinf_d = 1'b1;
            end
          end else if (!a_zero && !b_zero) begin
            state_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        if (mcnt_q != 3'd4) begin
          pp_d  = opa * opb;
          ppk_d = mcnt_q[1:0];
        end
        if (mcnt_q != 3'd0) begin
          case (ppk_q)
            2'd0:    prod_d = prod_q + 106'(pp_q);
            2'd3:    prod_d = prod_q + (106'(pp_q) << 64);
            default: prod_d = prod_q + (106'(pp_q) << 32);
          endcase
        end
        mcnt_d = mcnt_q + 3'd1;
        if (mcnt_q == 3'd4) begin
          state_d = S_SHF;
        end
      end
      S_SHF: begin
        v_d     = 192'(prod_q) << sh_q;
        state_d = S_ARD;
      end
      S_ARD: begin
        state_d = S_AWR;
      end
      S_AWR: begin
        we = 1'b1;
        valid_d[widx_q] = 1'b1;
        carry_d = sum65[64];
        if (((chunk_q < 2'd2) || sum65[64]) && (widx_q != TOP_ADDR)) begin
          widx_d  = widx_q + AW'(1);
          chunk_d = (chunk_q == 2'd3) ? 2'd3 : chunk_q + 2'd1;
          state_d = S_ARD;
        end else begin
          state_d = last_q ? S_FIN : S_IDLE;
        end
      end
      S_FIN: begin
        if (nan_q || (pinf_q && minf_q)) begin
          res_d = QNAN_BITS; state_d = S_OUT;
        end else if (pinf_q) begin
          res_d = INF_BITS; state_d = S_OUT;
        end else if (minf_q) begin
          res_d = {1'b1, INF_BITS[62:0]}; state_d = S_OUT;
        end else begin
          state_d = S_TOPR;
        end
      end
      S_TOPR: begin
        raddr   = TOP_ADDR;
        state_d = S_TOPW;
      end
      S_TOPW: begin
        sign_d  = rword[63];
        carry_d = 1'b1;
        cnt_d   = '0;
        prev_d  = 64'd0;
        orb_d   = 1'b0;
        found_d = 1'b0;
        state_d = S_SWP;
      end
      S_SWP: begin
        raddr = (cnt_q < CNT_END) ? cnt_q[AW-1:0] : '0;
        if (cnt_q != '0) begin
          carry_d = carry_q && (mag == 64'd0);
          orb_d   = orb_q || (prev_q != 64'd0);
          prev_d  = mag;
          if (mag != 64'd0) begin
            hi_d    = mag;
            lo_d    = prev_q;
            stlo_d  = orb_q;
            top_d   = AW'(cnt_q - CW'(1));
            found_d = 1'b1;
          end
        end
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CNT_END) begin
          state_d = S_SEL;
        end
      end
      S_SEL: begin
        win_d   = {hi_q, lo_q};
        p_d     = PW'({top_q, 6'h3f});
        st_d    = stlo_q;
        res_d   = 64'd0;
        state_d = found_q ? S_NORM : S_OUT;
      end
      S_NORM: begin
        if (p_q < P_NORM) begin
          if ((P_NORM - p_q) >= PW'(64)) begin
            st_d  = st_q || (|win_q[63:0]);
            win_d = win_q >> 64;
            p_d   = p_q + PW'(64);
          end else if ((P_NORM - p_q) >= PW'(8)) begin
            st_d  = st_q || (|win_q[7:0]);
            win_d = win_q >> 8;
            p_d   = p_q + PW'(8);
          end else begin
            st_d  = st_q || win_q[0];
            win_d = win_q >> 1;
            p_d   = p_q + PW'(1);
          end
        end else if (!win_q[127] && (p_q != P_NORM)) begin
          if ((win_q[127:120] == 8'd0) && ((p_q - P_NORM) >= PW'(8))) begin
            win_d = win_q << 8;
            p_d   = p_q - PW'(8);
          end else begin
            win_d = win_q << 1;
            p_d   = p_q - PW'(1);
          end
        end else begin
          state_d = S_RND;
        end
      end
      S_RND: begin
        if (qf[52]) begin
          if (ex >= PW'(2047)) begin
            res_d = {sign_q, INF_BITS[62:0]};
          end else begin
            res_d = {sign_q, ex[10:0], qf[51:0]};
          end
        end else begin
          res_d = {sign_q, 11'd0, qf[51:0]};
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          valid_d     = '0;
          nan_d = 1'b0; pinf_d = 1'b0; minf_d = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      nan_q       <= 1'b0;
      pinf_q      <= 1'b0;
      minf_q      <= 1'b0;
      valid_q     <= '0;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      nan_q       <= nan_d;
      pinf_q      <= pinf_d;
      minf_q      <= minf_d;
      valid_q     <= valid_d;
      rvalid_q    <= valid_q[raddr];
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q <= last_d; neg_q <= neg_d; ma_q <= ma_d; mb_q <= mb_d; sh_q <= sh_d;
    widx_q <= widx_d; chunk_q <= chunk_d; mcnt_q <= mcnt_d; ppk_q <= ppk_d;
    pp_q <= pp_d; prod_q <= prod_d; v_q <= v_d; carry_q <= carry_d;
    sign_q <= sign_d; cnt_q <= cnt_d; prev_q <= prev_d; hi_q <= hi_d;
    lo_q <= lo_d; orb_q <= orb_d; found_q <= found_d; stlo_q <= stlo_d;
    top_q <= top_d; win_q <= win_d; p_q <= p_d; st_q <= st_d; res_q <= res_d;
    out_data_q <= out_data_d;
  end

endmodule

// ----- design/edp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Exact double dot product checker
// Port level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module edp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_last_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [63:0] out_data_i
);

  // A stalled result beat holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result beat changed while stalled");

  // A closing beat keeps the input closed while the sum is rounded.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_last_i |=> !in_ready_i)
    else $error("input open right after a closing beat");

  // A new result appears only out of the busy rounding phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result raised while the input was open");

  // Reset removes any pending result.
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("result valid during reset");

endmodule

bind exact_double_dot_product_top edp_checker u_edp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_last_i   (in_i.last),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.result_bits)
);

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Exact double dot product testbench
// Sends vectors of binary64 pairs with random gaps on both channels. It
// predicts each rounded sum with its own wide accumulator and checks every
// result beat against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import edp_pkg::*;

  localparam int unsigned SUM_BITS   = 64 * ACC_WORDS_DEF;
  localparam int          LSB_WEIGHT = 2148;
  localparam int          SUBN_POS   = 1074;
  localparam int          STALL_MAX  = 4000;
  localparam logic [63:0] SIGN_BIT   = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX_NORM   = 64'h7FEF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MIN_SUBN   = 64'h0000_0000_0000_0001;
  localparam logic [63:0] ONE_BITS   = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] TWO_BITS   = 64'h4000_0000_0000_0000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic calm = 1'b0;
  int   n_errors = 0;
  int   quiet_cycles = 0;

  logic [SUM_BITS-1:0] run_sum = '0;
  logic                nan_flag = 1'b0;
  logic                pos_inf_flag = 1'b0;
  logic                neg_inf_flag = 1'b0;
  logic [63:0]         sums_due[$];

  edp_in_if  in_ch ();
  edp_out_if out_ch ();

  exact_double_dot_product_top uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  always #5 clk = ~clk;

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.a_bits = '0;
    in_ch.b_bits = '0;
    in_ch.last   = 1'b0;
    out_ch.ready = 1'b0;
  end

  function automatic logic [63:0] round_sum(input logic [SUM_BITS-1:0] total);
    logic [SUM_BITS-1:0] mag;
    logic [SUM_BITS-1:0] shifted;
    logic [63:0]         sign;
    logic [54:0]         q;
    logic                guard;
    logic                sticky;
    int                  p;
    int                  lsb;
    int                  e;
    sign = '0;
    mag  = total;
    p    = -1;
    if (total[SUM_BITS-1]) begin
      sign = SIGN_BIT;
      mag  = -total;
    end
    for (int i = SUM_BITS - 1; i >= 0; i--) begin
      if (mag[i]) begin
        p = i;
        break;
      end
    end
    if (p < 0) return '0;
    lsb = (p - 52 < SUBN_POS) ? SUBN_POS : p - 52;
    shifted = mag >> lsb;
    q = {1'b0, shifted[53:0]};
    guard = mag[lsb-1];
    sticky = (mag << (SUM_BITS - lsb + 1)) != '0;
    if (guard && (sticky || q[0])) q = q + 1;
    if (q == 55'(1) << 53) begin
      q = q >> 1;
      lsb++;
    end
    if (q >= 55'(1) << 52) begin
      e = lsb - (LSB_WEIGHT - 1075);
      if (e >= 2047) return sign | INF_BITS;
      return sign | (64'(e) << 52) | {12'h0, q[51:0]};
    end
    return sign | {9'h0, q};
  endfunction

  task automatic accumulate_pair(input logic [63:0] a, input logic [63:0] b,
                                 input logic last);
    logic [10:0]         ea;
    logic [10:0]         eb;
    logic [51:0]         fa;
    logic [51:0]         fb;
    logic [52:0]         ma;
    logic [52:0]         mb;
    logic [SUM_BITS-1:0] term;
    logic                neg;
    logic                a_zero;
    logic                b_zero;
    int                  pos;
    ea = a[62:52];
    eb = b[62:52];
    fa = a[51:0];
    fb = b[51:0];
    neg = a[63] ^ b[63];
    a_zero = (ea == 0) && (fa == 0);
    b_zero = (eb == 0) && (fb == 0);
    if ((ea == EXP_MAX && fa != 0) || (eb == EXP_MAX && fb != 0)) begin
      nan_flag = 1'b1;
    end else if (ea == EXP_MAX || eb == EXP_MAX) begin
      if (a_zero || b_zero) nan_flag = 1'b1;
      else if (neg) neg_inf_flag = 1'b1;
      else pos_inf_flag = 1'b1;
    end else if (!a_zero && !b_zero) begin
      ma = {ea != 0, fa};
      mb = {eb != 0, fb};
      pos = ((ea != 0) ? int'(ea) - 1075 : -1074) + ((eb != 0) ? int'(eb) - 1075 : -1074)
            + LSB_WEIGHT;
      term = SUM_BITS'(106'(ma) * 106'(mb)) << pos;
      run_sum = neg ? run_sum - term : run_sum + term;
    end
    if (last) begin
      if (nan_flag || (pos_inf_flag && neg_inf_flag)) sums_due.push_back(QNAN_BITS);
      else if (pos_inf_flag) sums_due.push_back(INF_BITS);
      else if (neg_inf_flag) sums_due.push_back(SIGN_BIT | INF_BITS);
      else sums_due.push_back(round_sum(run_sum));
      run_sum = '0;
      nan_flag = 1'b0;
      pos_inf_flag = 1'b0;
      neg_inf_flag = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    n_errors++;
    $display("ERROR %0t: %s got %h expected %h", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      accumulate_pair(in_ch.a_bits, in_ch.b_bits, in_ch.last);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (sums_due.size() == 0) report_mismatch("unexpected beat", out_ch.result_bits, '0);
      else if (out_ch.result_bits !== sums_due[0])
        report_mismatch("result_bits", out_ch.result_bits, sums_due.pop_front());
      else void'(sums_due.pop_front());
    end
  end

  int stall_left = 0;
  always @(posedge clk) begin
    if (calm) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= (stall_left == 1);
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 19);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (rst_n && quiet_cycles >= STALL_MAX) begin
      $display("exact_double_dot_product_top: mismatch");
      $finish;
    end
  end

  task automatic send_pair(input logic [63:0] a, input logic [63:0] b, input logic last);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.a_bits <= a;
    in_ch.b_bits <= b;
    in_ch.last   <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  function automatic logic [63:0] pick_operand();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 19))
      0, 1: ;
      2: v[62:52] = EXP_MAX;
      3: v[62:52] = 11'h0;
      4: v[62:0] = '0;
      5: v = {v[63], MAX_NORM[62:0]};
      6: v[62:52] = 11'(1 + $urandom_range(0, 2045));
      default: v[62:52] = 11'(1023 - 40 + $urandom_range(0, 80));
    endcase
    if (v[62:52] == EXP_MAX && $urandom_range(0, 1) == 0) v[51:0] = '0;
    return v;
  endfunction

  task automatic test_extremes();
    send_pair(MAX_NORM, MAX_NORM, 1'b1);
    send_pair(MAX_NORM | SIGN_BIT, MAX_NORM, 1'b1);
    send_pair(MIN_SUBN, MIN_SUBN, 1'b1);
    send_pair(MIN_SUBN, 64'h4330_0000_0000_0000, 1'b1);
    send_pair(64'h000F_FFFF_FFFF_FFFF, ONE_BITS | SIGN_BIT, 1'b1);
    send_pair(MAX_NORM, ONE_BITS, 1'b0);
    send_pair(MAX_NORM, ONE_BITS, 1'b1);
    send_pair(ONE_BITS, ONE_BITS, 1'b0);
    send_pair(ONE_BITS | SIGN_BIT, ONE_BITS, 1'b1);
    send_pair(ONE_BITS, ONE_BITS, 1'b0);
    send_pair(64'h3CA0_0000_0000_0000, ONE_BITS, 1'b1);
    send_pair(64'h0, SIGN_BIT, 1'b1);
  endtask

  task automatic test_special_values();
    send_pair(QNAN_BITS | 64'h1, ONE_BITS, 1'b1);
    send_pair(INF_BITS, 64'h0, 1'b1);
    send_pair(INF_BITS, TWO_BITS, 1'b0);
    send_pair(INF_BITS | SIGN_BIT, TWO_BITS, 1'b1);
    send_pair(INF_BITS | SIGN_BIT, TWO_BITS, 1'b0);
    send_pair(MAX_NORM, MAX_NORM, 1'b1);
    send_pair(INF_BITS, INF_BITS, 1'b0);
    send_pair(ONE_BITS, TWO_BITS, 1'b1);
    send_pair(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
  endtask

  task automatic random_vectors(input int n_items);
    logic [63:0] a;
    logic [63:0] b;
    int          len;
    int          sent;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        a = pick_operand();
        b = pick_operand();
        if (i + 1 < len && $urandom_range(0, 2) == 0) begin
          send_pair(a, b, 1'b0);
          a[63] = ~a[63];
          if ($urandom_range(0, 1) == 0) b[0] = ~b[0];
          i++;
          sent++;
        end
        send_pair(a, b, i >= len - 1);
        sent++;
      end
    end
  endtask

  task automatic test_random();
    random_vectors(1500);
  endtask

  task automatic test_back_to_back();
    calm = 1'b1;
    random_vectors(130);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_special_values();
    test_random();
    test_back_to_back();
    in_ch.valid <= 1'b0;
    while (sums_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (n_errors == 0) begin
      $display("exact_double_dot_product_top: match");
    end else begin
      $display("exact_double_dot_product_top: mismatch");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/edp_pkg.sv
design/edp_if.sv
design/edp_ram.sv
design/exact_double_dot_product_top.sv
design/edp_checker.sv
dv/tb_top.sv
